@@ rtl/qbpp_pkg.sv @@
package qbpp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 5;
  localparam int unsigned QUEUE_DEPTH_MAX     = 16;

  localparam logic [15:0] SHORT_BEEP_RESET  = 16'd50;
  localparam logic [15:0] LONG_BEEP_RESET   = 16'd250;
  localparam logic [15:0] SHORT_PAUSE_RESET = 16'd100;
  localparam logic [15:0] LONG_PAUSE_RESET  = 16'd500;

  // highest code that has a melody
  localparam logic [2:0] LAST_MELODY_CODE = 3'd4;

  typedef enum logic [1:0] {
    REG_SHORT_BEEP  = 2'd0,
    REG_LONG_BEEP   = 2'd1,
    REG_SHORT_PAUSE = 2'd2,
    REG_LONG_PAUSE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] short_beep_ms;
    logic [15:0] long_beep_ms;
    logic [15:0] short_pause_ms;
    logic [15:0] long_pause_ms;
  } cfg_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } queue_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [2:0] head_code;
  } queue_stat_t;

  typedef struct packed {
    logic        started;
    logic [11:0] pitch_hz;
    logic [15:0] length_ms;
    logic        active;
  } play_res_t;

  // note: bit 3 marks a long beep, bits 2:0 index the tone table
  function automatic logic [11:0] tone_hz(input logic [2:0] idx);
    logic [11:0] hz;
    case (idx)
      3'd0:    hz = 12'd2349;
      3'd1:    hz = 12'd2489;
      3'd2:    hz = 12'd2637;
      3'd3:    hz = 12'd2793;
      3'd4:    hz = 12'd2959;
      3'd5:    hz = 12'd3135;
      3'd6:    hz = 12'd880;
      3'd7:    hz = 12'd2217;
      default: hz = 12'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [2:0] melody_length(input logic [2:0] code);
    logic [2:0] len;
    case (code)
      3'd1:    len = 3'd4;
      3'd2:    len = 3'd2;
      3'd3:    len = 3'd3;
      3'd4:    len = 3'd3;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] melody_note(input logic [2:0] code,
                                             input logic [1:0] pos);
    logic [3:0] note;
    note = 4'd0;
    case (code)
      3'd1: begin
        case (pos)
          2'd0:    note = 4'd2;
          2'd1:    note = 4'd0;
          2'd2:    note = 4'd4;
          default: note = 4'd5;
        endcase
      end
      3'd3: begin
        case (pos)
          2'd0:    note = 4'd12;
          2'd1:    note = 4'd2;
          default: note = 4'd0;
        endcase
      end
      3'd4: begin
        case (pos)
          2'd0:    note = 4'd0;
          2'd1:    note = 4'd2;
          2'd2:    note = 4'd4;
          default: note = 4'd0;
        endcase
      end
      default: note = 4'd0;
    endcase
    return note;
  endfunction

endpackage

@@ rtl/qbpp_if.sv @@
interface qbpp_cmd_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [2:0] status_code;

  modport source (output valid, action, status_code, input ready);
  modport sink (input valid, action, status_code, output ready);
endinterface

interface qbpp_rsp_if;
  logic        valid;
  logic        ready;
  logic        enqueue_accepted;
  logic        beep_start;
  logic [11:0] beep_pitch_hz;
  logic [15:0] beep_length_ms;
  logic        pattern_active;
  logic [2:0]  queue_count;

  modport source (output valid, enqueue_accepted, beep_start, beep_pitch_hz,
                  beep_length_ms, pattern_active, queue_count, input ready);
  modport sink (input valid, enqueue_accepted, beep_start, beep_pitch_hz,
                beep_length_ms, pattern_active, queue_count, output ready);
endinterface

interface qbpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/queued_beep_pattern_player.sv @@
// Status melody player with a small code queue. Each command transaction is
// either an enqueue of a status code (codes 1 to 4 carry a melody, others are
// dropped when they reach the head) or one millisecond tick of the player.
// Every command gives exactly one response transaction. Commands pass an input
// register and the response register, so a new command is taken every
// cycle when the response side is not stalled; the whole queue, timer and
// melody step is combinational between those registers. The user writes beep
// and pause lengths through the config port while no command is in flight
// (not enforced by the block); they reset to 50, 250, 100 and 500 ticks.
module queued_beep_pattern_player #(
  parameter int unsigned QUEUE_DEPTH = qbpp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  qbpp_cmd_if.sink    cmd,
  qbpp_rsp_if.source  rsp,
  qbpp_cfg_if.sink    cfg
);

  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  qbpp_pkg::cfg_t        regs;
  qbpp_pkg::queue_ctrl_t qctrl;
  qbpp_pkg::queue_stat_t qstat;
  qbpp_pkg::play_res_t   pres;

  logic            s1_valid;
  logic            s1_action;
  logic [2:0]      s1_code;
  logic            s1_adv;
  logic            tick;
  logic            accepted;
  logic            deq;
  logic [CNTW-1:0] fill_next;

  assign s1_adv    = s1_valid && (!rsp.valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_adv;

  assign tick       = s1_adv && !s1_action;
  assign qctrl.enq  = s1_adv && s1_action;
  assign qctrl.deq  = deq;

  qbpp_config u_config (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  qbpp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (qctrl),
    .enq_code  (s1_code),
    .stat      (qstat),
    .accepted  (accepted),
    .fill_next (fill_next)
  );

  qbpp_player u_player (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .regs  (regs),
    .qstat (qstat),
    .deq   (deq),
    .res   (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_action <= cmd.action;
      s1_code   <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.enqueue_accepted <= accepted;
      rsp.beep_start       <= pres.started;
      rsp.beep_pitch_hz    <= pres.pitch_hz;
      rsp.beep_length_ms   <= pres.length_ms;
      rsp.pattern_active   <= pres.active;
      rsp.queue_count      <= 3'(fill_next);
    end
  end

endmodule

@@ rtl/qbpp_config.sv @@
module qbpp_config (
  input  logic              clk,
  input  logic              rst,
  qbpp_cfg_if.sink          cfg,
  output qbpp_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_beep_ms  <= qbpp_pkg::SHORT_BEEP_RESET;
      regs.long_beep_ms   <= qbpp_pkg::LONG_BEEP_RESET;
      regs.short_pause_ms <= qbpp_pkg::SHORT_PAUSE_RESET;
      regs.long_pause_ms  <= qbpp_pkg::LONG_PAUSE_RESET;
    end else if (cfg.valid) begin
      case (qbpp_pkg::cfg_reg_e'(cfg.index))
        qbpp_pkg::REG_SHORT_BEEP:  regs.short_beep_ms  <= cfg.data;
        qbpp_pkg::REG_LONG_BEEP:   regs.long_beep_ms   <= cfg.data;
        qbpp_pkg::REG_SHORT_PAUSE: regs.short_pause_ms <= cfg.data;
        qbpp_pkg::REG_LONG_PAUSE:  regs.long_pause_ms  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/qbpp_queue.sv @@
module qbpp_queue #(
  parameter int unsigned QUEUE_DEPTH = qbpp_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int unsigned IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  qbpp_pkg::queue_ctrl_t   ctrl,
  input  logic [2:0]              enq_code,
  output qbpp_pkg::queue_stat_t   stat,
  output logic                    accepted,
  output logic [CNTW-1:0]         fill_next
);

  localparam logic [IDXW:0]   DEPTH_W = (IDXW + 1)'(QUEUE_DEPTH);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(QUEUE_DEPTH - 1);

  logic [2:0]      slots [QUEUE_DEPTH];
  logic [IDXW-1:0] head;
  logic [IDXW-1:0] head_next;
  logic [CNTW-1:0] fill;
  logic [IDXW:0]   tail_sum;
  logic [IDXW-1:0] tail;
  logic            do_deq;

  assign stat.empty     = (fill == '0);
  assign stat.full      = (fill == CNTW'(QUEUE_DEPTH));
  assign stat.head_code = slots[head];

  assign accepted = ctrl.enq && !stat.full;
  assign do_deq   = ctrl.deq && !stat.empty;

  // head + fill stays below twice the depth, one subtract wraps it
  assign tail_sum = {1'b0, head} + (IDXW + 1)'(fill);
  assign tail     = (tail_sum >= DEPTH_W) ? IDXW'(tail_sum - DEPTH_W) : IDXW'(tail_sum);

  assign head_next = (head == LAST_IDX) ? '0 : head + 1'b1;

  always_comb begin
    fill_next = fill;
    if (accepted) begin
      fill_next = fill + 1'b1;
    end else if (do_deq) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (do_deq) begin
        head <= head_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      slots[tail] <= enq_code;
    end
  end

endmodule

@@ rtl/qbpp_player.sv @@
module qbpp_player (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  qbpp_pkg::cfg_t        regs,
  input  qbpp_pkg::queue_stat_t qstat,
  output logic                  deq,
  output qbpp_pkg::play_res_t   res
);

  logic [16:0] wait_counter;
  logic [16:0] wait_counter_next;
  logic [2:0]  note_position;
  logic [2:0]  note_position_next;
  logic        playing;
  logic        playing_next;
  logic [2:0]  current_code;
  logic [2:0]  current_code_next;

  logic        expired;
  logic        keep;
  logic [3:0]  note;
  logic [15:0] dur;

  assign expired = (wait_counter == '0);
  assign note    = qbpp_pkg::melody_note(current_code_next, note_position[1:0]);
  assign dur     = note[3] ? regs.long_beep_ms : regs.short_beep_ms;

  always_comb begin
    wait_counter_next  = expired ? wait_counter : wait_counter - 1'b1;
    note_position_next = note_position;
    playing_next       = playing;
    current_code_next  = current_code;
    keep               = 1'b1;
    res.started        = 1'b0;
    res.pitch_hz       = '0;
    res.length_ms      = '0;

    if (!qstat.empty) begin
      keep = 1'b0;
      if (qstat.head_code <= qbpp_pkg::LAST_MELODY_CODE) begin
        if (!playing) begin
          current_code_next = qstat.head_code;
        end
        if (qstat.head_code != '0) begin
          playing_next = 1'b1;
        end
        if (expired && playing_next) begin
          if (note_position < qbpp_pkg::melody_length(current_code_next)) begin
            res.started        = 1'b1;
            res.pitch_hz       = qbpp_pkg::tone_hz(note[2:0]);
            res.length_ms      = dur;
            wait_counter_next  = {1'b0, dur} + {1'b0, regs.short_pause_ms};
            note_position_next = note_position + 1'b1;
          end else begin
            // pattern finished: long gap, code leaves the queue
            wait_counter_next  = {1'b0, regs.long_pause_ms};
            note_position_next = '0;
            playing_next       = 1'b0;
          end
        end
        keep = playing_next;
      end
    end

    if (!tick) begin
      res.started   = 1'b0;
      res.pitch_hz  = '0;
      res.length_ms = '0;
    end

    res.active = tick ? playing_next : playing;
  end

  assign deq = tick && !keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_counter  <= '0;
      note_position <= '0;
      playing       <= 1'b0;
      current_code  <= '0;
    end else if (tick) begin
      wait_counter  <= wait_counter_next;
      note_position <= note_position_next;
      playing       <= playing_next;
      current_code  <= current_code_next;
    end
  end

endmodule
